// File: design/esc_pkg.sv
// package for the environmental sensor compensation pipeline
// register indexes, widths and the pipeline depth; no dependencies
package esc_pkg;

   localparam int unsigned CsrIndexWidth = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TEMP_CAL       = 3'd0,
      CSR_PRESS_CAL_LOW  = 3'd1,
      CSR_PRESS_CAL_HIGH = 3'd2,
      CSR_PRESS_CAL_NINE = 3'd3,
      CSR_HUM_CAL        = 3'd4
   } csr_index_type;

   localparam int unsigned DivSteps = 32;
   localparam int unsigned PreStages = 6;
   localparam int unsigned PostStages = 4;
   localparam int unsigned Depth = PreStages + DivSteps + PostStages;

   localparam logic [31:0] HumOffset = 32'd76800;
   localparam logic [31:0] HumMax = 32'd419430400;
   localparam logic [31:0] PressOffset = 32'd64000;
   localparam logic [31:0] PressBase = 32'd1048576;
   localparam logic [31:0] PressScale = 32'd3125;

   // signed 32-bit product, wrapped
   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

endpackage

// File: design/esc_divider.sv
// restoring divider pipeline, one quotient bit a stage, with sideband
// depends on esc_pkg
module esc_divider
   import esc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_num,
   input  logic [31:0] in_den,
   input  logic        in_half,
   input  logic [63:0] in_side,
   output logic        out_valid,
   output logic [31:0] out_quot,
   output logic [31:0] out_den,
   output logic [63:0] out_side
);

   logic                    v_ff [DivSteps];
   logic [31:0]             n_ff [DivSteps];
   logic [31:0]             r_ff [DivSteps];
   logic [31:0]             d_ff [DivSteps];
   logic                    h_ff [DivSteps];
   logic [63:0]             s_ff [DivSteps];

   for (genvar i = 0; i < DivSteps; i++) begin : g_step
      logic        v_cur, h_cur;
      logic [31:0] n_cur, r_cur, d_cur;
      logic [63:0] s_cur;
      logic [32:0] t_rem;
      logic [31:0] r_in;
      logic [31:0] n_in;
      if (i == 0) begin : g_first
         assign v_cur = in_valid;
         assign n_cur = in_num;
         assign r_cur = '0;
         assign d_cur = in_den;
         assign h_cur = in_half;
         assign s_cur = in_side;
      end else begin : g_next
         assign v_cur = v_ff[i-1];
         assign n_cur = n_ff[i-1];
         assign r_cur = r_ff[i-1];
         assign d_cur = d_ff[i-1];
         assign h_cur = h_ff[i-1];
         assign s_cur = s_ff[i-1];
      end
      always_comb begin
         t_rem = {r_cur, n_cur[31]};
         if (t_rem >= {1'b0, d_cur}) begin
            r_in = 32'(t_rem - {1'b0, d_cur});
            n_in = {n_cur[30:0], 1'b1};
         end else begin
            r_in = t_rem[31:0];
            n_in = {n_cur[30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= v_cur;
         end
         r_ff[i] <= r_in;
         n_ff[i] <= n_in;
         d_ff[i] <= d_cur;
         h_ff[i] <= h_cur;
         s_ff[i] <= s_cur;
      end
   end

   assign out_valid = v_ff[DivSteps-1];
   assign out_quot = h_ff[DivSteps-1] ? {n_ff[DivSteps-1][30:0], 1'b0} : n_ff[DivSteps-1];
   assign out_den = d_ff[DivSteps-1];
   assign out_side = s_ff[DivSteps-1];

endmodule

// File: design/env_sensor_compensation.sv
// environmental sensor compensation top level: calibration registers and pipeline
// depends on esc_pkg and esc_divider
//
//   channel   ports                     handshake
//   request   start / busy              start high, busy low
//   result    rsp_strobe                one cycle, no back-pressure
//   csr       csr_valid / csr_ready     valid and ready
//
// one request per cycle; each result passes through the 32 single-bit stages
// of the pressure divider plus 10 arithmetic stages. busy is always low.
// reset clears valid bits and the calibration registers. the receiver
// cannot stall, so nothing is held back.
module env_sensor_compensation
   import esc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   input  logic [15:0] req_raw_humidity,
   output logic        rsp_strobe,
   output logic [31:0] rsp_temperature_centideg,
   output logic [16:0] rsp_humidity_q10,
   output logic [31:0] rsp_pressure_pa,
   output logic        rsp_divisor_zero,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [47:0] temp_cal_ff;
   logic [63:0] pl_ff, ph_ff, hum_cal_ff;
   logic [15:0] p9_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '0;
         pl_ff <= '0;
         ph_ff <= '0;
         p9_ff <= '0;
         hum_cal_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TEMP_CAL:       temp_cal_ff <= csr_data[47:0];
            CSR_PRESS_CAL_LOW:  pl_ff <= csr_data;
            CSR_PRESS_CAL_HIGH: ph_ff <= csr_data;
            CSR_PRESS_CAL_NINE: p9_ff <= csr_data[15:0];
            CSR_HUM_CAL:        hum_cal_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;
   always_comb begin
      t1 = {16'd0, temp_cal_ff[15:0]};
      t2 = 32'($signed(temp_cal_ff[31:16]));
      t3 = 32'($signed(temp_cal_ff[47:32]));
      p1 = {16'd0, pl_ff[15:0]};
      p2 = 32'($signed(pl_ff[31:16]));
      p3 = 32'($signed(pl_ff[47:32]));
      p4 = 32'($signed(pl_ff[63:48]));
      p5 = 32'($signed(ph_ff[15:0]));
      p6 = 32'($signed(ph_ff[31:16]));
      p7 = 32'($signed(ph_ff[47:32]));
      p8 = 32'($signed(ph_ff[63:48]));
      p9 = 32'($signed(p9_ff));
      h1 = {24'd0, hum_cal_ff[7:0]};
      h2 = 32'($signed(hum_cal_ff[23:8]));
      h3 = {24'd0, hum_cal_ff[31:24]};
      h4 = 32'($signed(hum_cal_ff[43:32]));
      h5 = 32'($signed(hum_cal_ff[55:44]));
      h6 = 32'($signed(hum_cal_ff[63:56]));
   end

   // stage 1: temperature products
   logic        v1_ff;
   logic [31:0] s1_at_ff, s1_bb_ff;
   logic [19:0] s1_up_ff;
   logic [15:0] s1_uh_ff;
   logic [31:0] ut, a_in, b_in;
   always_comb begin
      ut = {12'd0, req_raw_temperature};
      a_in = (ut >> 3) - (t1 << 1);
      b_in = (ut >> 4) - t1;
   end
   always_ff @(posedge clock) begin
      v1_ff <= reset ? 1'b0 : start;
      s1_at_ff <= mul32(a_in, t2);
      s1_bb_ff <= mul32(b_in, b_in);
      s1_up_ff <= req_raw_pressure;
      s1_uh_ff <= req_raw_humidity;
   end

   // stage 2: t_fine
   logic        v2_ff;
   logic [31:0] s2_tf_ff;
   logic [19:0] s2_up_ff;
   logic [15:0] s2_uh_ff;
   logic [31:0] v2t_in;
   always_comb v2t_in = asr32(mul32(asr32(s1_bb_ff, 12), t3), 14);
   always_ff @(posedge clock) begin
      v2_ff <= reset ? 1'b0 : v1_ff;
      s2_tf_ff <= asr32(s1_at_ff, 11) + v2t_in;
      s2_up_ff <= s1_up_ff;
      s2_uh_ff <= s1_uh_ff;
   end

   // stage 3: first level products
   logic        v3_ff;
   logic [31:0] s3_tf_ff, s3_h5x_ff, s3_pb_ff, s3_pc_ff, s3_qq_ff;
   logic [31:0] s3_v1p5_ff, s3_p2v1_ff;
   logic [19:0] s3_up_ff;
   logic [15:0] s3_uh_ff;
   logic [31:0] x3, pv1_3, q3;
   always_comb begin
      x3 = s2_tf_ff - HumOffset;
      pv1_3 = asr32(s2_tf_ff, 1) - PressOffset;
      q3 = asr32(pv1_3, 2);
   end
   always_ff @(posedge clock) begin
      v3_ff <= reset ? 1'b0 : v2_ff;
      s3_tf_ff <= s2_tf_ff;
      s3_h5x_ff <= mul32(h5, x3);
      s3_pb_ff <= asr32(mul32(x3, h6), 10);
      s3_pc_ff <= asr32(mul32(x3, h3), 11) + 32'd32768;
      s3_qq_ff <= mul32(q3, q3);
      s3_v1p5_ff <= mul32(pv1_3, p5);
      s3_p2v1_ff <= mul32(p2, pv1_3);
      s3_up_ff <= s2_up_ff;
      s3_uh_ff <= s2_uh_ff;
   end

   // stage 4: second level products
   logic        v4_ff;
   logic [31:0] s4_tf_ff, s4_pa_ff, s4_pbc_ff, s4_v2_ff, s4_p3q_ff, s4_p2v1_ff;
   logic [19:0] s4_up_ff;
   logic [31:0] pa4;
   always_comb begin
      pa4 = asr32(({16'd0, s3_uh_ff} << 14) - (h4 << 20) - s3_h5x_ff + 32'd16384, 15);
   end
   always_ff @(posedge clock) begin
      v4_ff <= reset ? 1'b0 : v3_ff;
      s4_tf_ff <= s3_tf_ff;
      s4_pa_ff <= pa4;
      s4_pbc_ff <= mul32(s3_pb_ff, s3_pc_ff);
      s4_v2_ff <= mul32(asr32(s3_qq_ff, 11), p6) + (s3_v1p5_ff << 1);
      s4_p3q_ff <= mul32(p3, asr32(s3_qq_ff, 13));
      s4_p2v1_ff <= s3_p2v1_ff;
      s4_up_ff <= s3_up_ff;
   end

   // stage 5: humidity pd*h2, pressure var1
   logic        v5_ff;
   logic [31:0] s5_tf_ff, s5_pa_ff, s5_pdh_ff, s5_v2_ff, s5_v1_ff;
   logic [19:0] s5_up_ff;
   logic [31:0] pd5, v1a5;
   always_comb begin
      pd5 = asr32(s4_pbc_ff, 10) + 32'd2097152;
      v1a5 = asr32(asr32(s4_p3q_ff, 3) + asr32(s4_p2v1_ff, 1), 18);
   end
   always_ff @(posedge clock) begin
      v5_ff <= reset ? 1'b0 : v4_ff;
      s5_tf_ff <= s4_tf_ff;
      s5_pa_ff <= s4_pa_ff;
      s5_pdh_ff <= mul32(pd5, h2);
      s5_v2_ff <= asr32(s4_v2_ff, 2) + (p4 << 16);
      s5_v1_ff <= mul32(32'd32768 + v1a5, p1);
      s5_up_ff <= s4_up_ff;
   end

   // stage 6: humidity pa*pe, pressure dividend
   logic        v6_ff;
   logic [31:0] s6_tf_ff, s6_x_ff, s6_p_ff, s6_div_ff;
   logic [31:0] pe6, pdiv6, praw6;
   always_comb begin
      pe6 = asr32(s5_pdh_ff + 32'd8192, 14);
      pdiv6 = asr32(s5_v1_ff, 15);
      praw6 = mul32((PressBase - {12'd0, s5_up_ff}) - asr32(s5_v2_ff, 12), PressScale);
   end
   always_ff @(posedge clock) begin
      v6_ff <= reset ? 1'b0 : v5_ff;
      s6_tf_ff <= s5_tf_ff;
      s6_x_ff <= mul32(s5_pa_ff, pe6);
      s6_p_ff <= praw6;
      s6_div_ff <= pdiv6;
   end

   // temperature finishes here; it and the humidity product ride along the divider
   logic [31:0] temp6;
   always_comb temp6 = asr32(mul32(s6_tf_ff, 32'd5) + 32'd128, 8);

   logic        dv_valid;
   logic [31:0] dq, dden;
   logic [63:0] dside;
   logic        half;
   logic [31:0] num;
   always_comb begin
      half = s6_p_ff[31];
      num = half ? s6_p_ff : (s6_p_ff << 1);
   end

   esc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_num    (num),
      .in_den    (s6_div_ff),
      .in_half   (half),
      .in_side   ({temp6, s6_x_ff}),
      .out_valid (dv_valid),
      .out_quot  (dq),
      .out_den   (dden),
      .out_side  (dside)
   );

   // post 1: pressure products, humidity square
   logic        w1_ff, w1_dz_ff;
   logic [31:0] w1_p_ff, w1_qq_ff, w1_pp8_ff;
   logic [31:0] w1_hx_ff, w1_hsq_ff, w1_temp_ff;
   logic [31:0] q_w, hs_w;
   always_comb begin
      q_w = dq >> 3;
      hs_w = asr32(dside[31:0], 15);
   end
   always_ff @(posedge clock) begin
      w1_ff <= reset ? 1'b0 : dv_valid;
      w1_dz_ff <= (dden == '0);
      w1_p_ff <= dq;
      w1_qq_ff <= mul32(q_w, q_w);
      w1_pp8_ff <= asr32(mul32(dq >> 2, p8), 13);
      w1_hx_ff <= dside[31:0];
      w1_hsq_ff <= mul32(hs_w, hs_w);
      w1_temp_ff <= dside[63:32];
   end

   // post 2
   logic        w2_ff, w2_dz_ff;
   logic [31:0] w2_p_ff, w2_v1_ff, w2_v2_ff;
   logic [31:0] w2_hx_ff, w2_temp_ff;
   always_ff @(posedge clock) begin
      w2_ff <= reset ? 1'b0 : w1_ff;
      w2_dz_ff <= w1_dz_ff;
      w2_p_ff <= w1_p_ff;
      w2_v1_ff <= asr32(mul32(p9, w1_qq_ff >> 13), 12);
      w2_v2_ff <= w1_pp8_ff;
      w2_hx_ff <= w1_hx_ff - asr32(mul32(asr32(w1_hsq_ff, 7), h1), 4);
      w2_temp_ff <= w1_temp_ff;
   end

   // post 3: pressure sum, humidity clamp
   logic        w3_ff, w3_dz_ff;
   logic [31:0] w3_p_ff, w3_temp_ff;
   logic [16:0] w3_hum_ff;
   logic [16:0] hum3;
   always_comb begin
      if (w2_hx_ff[31]) begin
         hum3 = '0;
      end else if (w2_hx_ff > HumMax) begin
         hum3 = 17'(HumMax >> 12);
      end else begin
         hum3 = 17'(w2_hx_ff >> 12);
      end
   end
   always_ff @(posedge clock) begin
      w3_ff <= reset ? 1'b0 : w2_ff;
      w3_dz_ff <= w2_dz_ff;
      w3_p_ff <= w2_dz_ff ? '0 : w2_p_ff + asr32(w2_v1_ff + w2_v2_ff + p7, 4);
      w3_hum_ff <= hum3;
      w3_temp_ff <= w2_temp_ff;
   end

   // post 4: output register
   logic        w4_ff, w4_dz_ff;
   logic [31:0] w4_p_ff, w4_temp_ff;
   logic [16:0] w4_hum_ff;
   always_ff @(posedge clock) begin
      w4_ff <= reset ? 1'b0 : w3_ff;
      w4_dz_ff <= w3_dz_ff;
      w4_p_ff <= w3_p_ff;
      w4_hum_ff <= w3_hum_ff;
      w4_temp_ff <= w3_temp_ff;
   end

   assign rsp_strobe = w4_ff;
   assign rsp_temperature_centideg = w4_temp_ff;
   assign rsp_humidity_q10 = w4_hum_ff;
   assign rsp_pressure_pa = w4_p_ff;
   assign rsp_divisor_zero = w4_dz_ff;

endmodule
